@@ src/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/gesq_pkg.sv @@
package gesq_pkg;

	localparam int unsigned NUM_CLASSES = 6;

	localparam int unsigned CLASS_W = 4;
	localparam int unsigned CONF_W  = 8;
	localparam int unsigned RUN_W   = 4;
	localparam int unsigned TIME_W  = 48;
	localparam int unsigned COOL_W  = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [RUN_W-1:0]   RUN_MAX        = 4'd15;
	localparam logic [CLASS_W-1:0] CLASS_BACKGROUND = 4'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CONF_TH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARG_TH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd3;

	// reset values
	localparam logic [CONF_W-1:0] CONF_TH_RST  = 8'd180;
	localparam logic [CONF_W-1:0] MARG_TH_RST  = 8'd39;
	localparam logic [RUN_W-1:0]  STABLE_RST   = 4'd4;
	localparam logic [COOL_W-1:0] COOLDOWN_RST = 32'd1500000;

	typedef struct packed {
		logic [CONF_W-1:0] conf_th;
		logic [CONF_W-1:0] marg_th;
		logic [RUN_W-1:0]  stable_cnt;
		logic [COOL_W-1:0] cooldown;
	} cfg_t;

	typedef struct packed {
		logic [CLASS_W-1:0] gesture_class;
		logic [CONF_W-1:0]  confidence;
		logic [CONF_W-1:0]  margin;
		logic [TIME_W-1:0]  timestamp;
	} item_t;

	typedef struct packed {
		logic               stable_changed;
		logic               action_fired;
		logic [CLASS_W-1:0] reported_class;
		logic [CONF_W-1:0]  reported_confidence;
	} result_t;

endpackage

@@ src/gesq_cfg.sv @@
module gesq_cfg import gesq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_th    <= CONF_TH_RST;
			cfg_q.marg_th    <= MARG_TH_RST;
			cfg_q.stable_cnt <= STABLE_RST;
			cfg_q.cooldown   <= COOLDOWN_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_CONF_TH:  cfg_q.conf_th    <= cfg_data[CONF_W-1:0];
				CFG_MARG_TH:  cfg_q.marg_th    <= cfg_data[CONF_W-1:0];
				CFG_STABLE:   cfg_q.stable_cnt <= cfg_data[RUN_W-1:0];
				CFG_COOLDOWN: cfg_q.cooldown   <= cfg_data[COOL_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/gesq_core.sv @@
module gesq_core import gesq_pkg::*; #(
	parameter int unsigned N_CLASSES = NUM_CLASSES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic               cand_valid_q;
	logic [CLASS_W-1:0] cand_class_q;
	logic [RUN_W-1:0]   run_q;
	logic               stable_valid_q;
	logic [CLASS_W-1:0] stable_class_q;
	logic [TIME_W-1:0]  last_fire_q;
	logic               armed_q;

	logic               in_range;
	logic               same;
	logic               fresh;
	logic [RUN_W-1:0]   run_next;
	logic               qual;
	logic               changed;
	logic               is_bg;
	logic [TIME_W-1:0]  elapsed;
	logic               cooled;
	logic               fired;

	assign in_range = {1'b0, item.gesture_class} < (CLASS_W+1)'(N_CLASSES);
	assign same     = cand_valid_q && (item.gesture_class == cand_class_q);
	assign fresh    = !same || (run_q < RUN_MAX);
	assign is_bg    = item.gesture_class == CLASS_BACKGROUND;

	always_comb begin
		if (!same)
			run_next = RUN_W'(1);
		else if (fresh)
			run_next = run_q + RUN_W'(1);
		else
			run_next = run_q;
	end

	// qualify only on the frame that brings the run to the stable count
	assign qual = in_range && fresh && (run_next == cfg.stable_cnt)
		&& (item.confidence >= cfg.conf_th);
	assign changed = qual && (!stable_valid_q || (stable_class_q != item.gesture_class));

	// backwards time never cools down
	assign elapsed = item.timestamp - last_fire_q;
	assign cooled  = (item.timestamp >= last_fire_q)
		&& (elapsed > {{(TIME_W-COOL_W){1'b0}}, cfg.cooldown});
	assign fired   = qual && !is_bg && armed_q && cooled && (item.margin >= cfg.marg_th);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_valid_q   <= 1'b0;
			cand_class_q   <= '0;
			run_q          <= '0;
			stable_valid_q <= 1'b0;
			stable_class_q <= '0;
			last_fire_q    <= '0;
			armed_q        <= 1'b1;
		end else if (step && in_range) begin
			cand_valid_q <= 1'b1;
			cand_class_q <= item.gesture_class;
			run_q        <= run_next;
			if (qual) begin
				stable_valid_q <= 1'b1;
				stable_class_q <= item.gesture_class;
			end
			if (qual && is_bg)
				armed_q <= 1'b1;
			if (fired) begin
				last_fire_q <= item.timestamp;
				armed_q     <= 1'b0;
			end
		end
	end

	assign res.stable_changed      = changed;
	assign res.action_fired        = fired;
	assign res.reported_class      = in_range ? item.gesture_class : cand_class_q;
	assign res.reported_confidence = item.confidence;

endmodule

@@ src/gesture_event_qualifier_unit.sv @@
// Gesture event qualifier.
// Input channel (in_valid/in_ready) takes one classified frame per transaction:
// class, top-1 confidence, top-1/top-2 margin (1/256 units) and a microsecond
// timestamp. Output channel (out_valid/out_ready) returns exactly one result per
// frame, in order: stable_changed, action_fired, reported_class and the
// confidence passed through.
// Config port: cfg_wen writes cfg_data into the register picked by cfg_index
// (0 confidence threshold, 1 margin threshold, 2 stable count, 3 cooldown us).
// Write only while no frame is in flight.
// Path: a frame taken into the input stage moves on to the result register,
// and so to the out port, when the result register is free or draining.
// Throughput: one frame per cycle while out_ready is high; the per-frame
// update is a single combinational compare/count/subtract pass.
// Reset: config returns to defaults, the run/stable/cooldown state clears
// (armed set), both pipeline stages empty.
// Stall: the result register holds while out_ready is low; the input stage
// still takes one more frame, then in_ready drops until the result moves.
module gesture_event_qualifier_unit import gesq_pkg::*; #(
	parameter int unsigned N_CLASSES = NUM_CLASSES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CLASS_W-1:0]    gesture_class,
	input  logic [CONF_W-1:0]     confidence,
	input  logic [CONF_W-1:0]     margin,
	input  logic [TIME_W-1:0]     timestamp,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  stable_changed,
	output logic                  action_fired,
	output logic [CLASS_W-1:0]    reported_class,
	output logic [CONF_W-1:0]     reported_confidence,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    in_xfer;
	logic    adv;

	gesq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves into the result register when that register is free or draining;
	// the frame's state update happens on the same edge
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_xfer)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.gesture_class <= gesture_class;
			item_s1.confidence    <= confidence;
			item_s1.margin        <= margin;
			item_s1.timestamp     <= timestamp;
		end
	end

	gesq_core #(
		.N_CLASSES (N_CLASSES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid           = valid_s2;
	assign stable_changed      = res_s2.stable_changed;
	assign action_fired        = res_s2.action_fired;
	assign reported_class      = res_s2.reported_class;
	assign reported_confidence = res_s2.reported_confidence;

endmodule

@@ src/gesq_checker.sv @@
`include "assert_macros.svh"

module gesq_checker import gesq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [CLASS_W-1:0]    gesture_class,
	input logic [TIME_W-1:0]     timestamp,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  action_fired,
	input logic [CLASS_W-1:0]    reported_class,
	input logic [CONF_W-1:0]     reported_confidence
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(action_fired) && $stable(reported_class) && $stable(reported_confidence))

	// a waiting frame holds
	`ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(gesture_class) && $stable(timestamp))

	// with the result register empty the input side is never blocked
	`ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// background never fires an action
	`ASSERT_IMPLY(a_fire_not_bg, clk, arst_n, out_valid && action_fired, reported_class != CLASS_BACKGROUND)

	// two transactions in a row cannot both fire (firing disarms until background qualifies)
	`ASSERT_NEXT(a_no_double_fire, clk, arst_n, out_valid && out_ready && action_fired, !(out_valid && action_fired))

endmodule

bind gesture_event_qualifier_unit gesq_checker u_gesq_checker (.*);
